// ----- design/unsigned_radix_to_ascii_macros.svh -----
// Assertion macros used by the checker file ura_checker.sv.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef UNSIGNED_RADIX_TO_ASCII_MACROS_SVH
`define UNSIGNED_RADIX_TO_ASCII_MACROS_SVH

// Same-cycle implication.
`define URA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define URA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ura_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ura_pkg
// Shared types, codes and helpers of the radix-to-ASCII converter.
// ----------------------------------------------------------------------------
package ura_pkg;

  localparam int unsigned VALUE_BITS        = 64;
  localparam int unsigned VALUE_WIDTH_DEF   = 64;
  localparam int unsigned CHAR_W            = 7;
  localparam int unsigned DIGIT_W           = 4;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_BIN = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd97;

  typedef struct packed {
    logic load;
    logic step;
    logic rd_en;
    logic pop;
  } ura_cmd_t;

  typedef struct packed {
    logic digit_done;
    logic quot_zero;
    logic cnt_one;
  } ura_sts_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      glyph = CHAR_ZERO + ext;
    end else begin
      glyph = CHAR_A + ext - 7'd10;
    end
  endfunction

endpackage

// ----- design/ura_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ura_datapath
// Digit extraction unit, digit store and output character register.
// ----------------------------------------------------------------------------
module ura_datapath #(
  parameter int unsigned VALUE_WIDTH = ura_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ura_pkg::ura_cmd_t               cmd_i,
  output ura_pkg::ura_sts_t               sts_o,
  input  logic [ura_pkg::VALUE_BITS-1:0]  value_i,
  input  logic [1:0]                      radix_code_i,
  output logic [ura_pkg::CHAR_W-1:0]      digit_char_o
);

  localparam int unsigned CHUNKS = (VALUE_WIDTH + 7) / 8;
  localparam int unsigned PW     = CHUNKS * 8;
  localparam int unsigned CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned DEPTH  = VALUE_WIDTH;
  localparam int unsigned AW     = $clog2(DEPTH);
  // 3277 / 2^15 approximates 1/10; exact for dividends below 16384
  localparam logic [11:0] RECIP10 = 12'd3277;

  logic [PW-1:0]                  val_q, val_d;
  logic [1:0]                     rad_q;
  logic [3:0]                     rem_q, rem_d;
  logic [CHW-1:0]                 chunk_q, chunk_d;
  logic [AW:0]                    cnt_q, cnt_d;
  logic [ura_pkg::DIGIT_W-1:0]    mem [DEPTH];
  logic [ura_pkg::DIGIT_W-1:0]    rd_q;

  logic [11:0]                    dec_x;
  logic [23:0]                    dec_prod;
  logic [7:0]                     dec_q8;
  logic [11:0]                    dec_r12;
  logic [PW+7:0]                  dec_cat;
  logic                           is_dec;
  logic                           chunk_last;
  logic [PW-1:0]                  nxt_val;
  logic [3:0]                     digit;
  logic                           wr_en;
  logic [AW:0]                    rd_ptr;

  assign is_dec     = (rad_q == ura_pkg::RADIX_DEC);
  assign chunk_last = (chunk_q == CHW'(CHUNKS - 1));

  // Long division by ten, one byte of the dividend per cycle, MSB first
  assign dec_x    = {rem_q, val_q[PW-1 -: 8]};
  assign dec_prod = dec_x * RECIP10;
  assign dec_q8   = dec_prod[22:15];
  assign dec_r12  = dec_x - ({4'd0, dec_q8} * 12'd10);
  assign dec_cat  = {val_q, dec_q8};

  always_comb begin
    nxt_val = val_q;
    digit   = 4'd0;
    case (rad_q)
      ura_pkg::RADIX_HEX: begin
        nxt_val = val_q >> 4;
        digit   = val_q[3:0];
      end
      ura_pkg::RADIX_OCT: begin
        nxt_val = val_q >> 3;
        digit   = {1'b0, val_q[2:0]};
      end
      ura_pkg::RADIX_BIN: begin
        nxt_val = val_q >> 1;
        digit   = {3'd0, val_q[0]};
      end
      default: begin
        nxt_val = dec_cat[PW-1:0];
        digit   = dec_r12[3:0];
      end
    endcase
  end

  assign wr_en = cmd_i.step && (!is_dec || chunk_last);

  always_comb begin
    val_d   = val_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    cnt_d   = cnt_q;
    if (cmd_i.load) begin
      val_d   = PW'(value_i[VALUE_WIDTH-1:0]);
      rem_d   = 4'd0;
      chunk_d = '0;
      cnt_d   = '0;
    end else if (cmd_i.step) begin
      val_d = nxt_val;
      if (is_dec) begin
        if (chunk_last) begin
          rem_d   = 4'd0;
          chunk_d = '0;
        end else begin
          rem_d   = dec_r12[3:0];
          chunk_d = chunk_q + 1'b1;
        end
      end
      if (wr_en) begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      cnt_q   <= '0;
    end else begin
      chunk_q <= chunk_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      rad_q <= radix_code_i;
    end
  end

  assign rd_ptr = cnt_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= digit;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_ptr[AW-1:0]];
    end
  end

  assign sts_o.digit_done = wr_en;
  assign sts_o.quot_zero  = (nxt_val == '0);
  assign sts_o.cnt_one    = (cnt_q == (AW+1)'(1));
  assign digit_char_o     = ura_pkg::glyph(rd_q);

endmodule

// ----- design/ura_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ura_controller
// Sequencer: accept, convert, then read back and present each character.
// ----------------------------------------------------------------------------
module ura_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ura_pkg::ura_sts_t sts_i,
  output ura_pkg::ura_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_READ,
    ST_SHOW
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  assign cmd_o.load  = in_valid_i && in_ready_q;
  assign cmd_o.step  = (state_q == ST_CONV);
  assign cmd_o.rd_en = (state_q == ST_READ);
  assign cmd_o.pop   = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q    <= ST_CONV;
            in_ready_q <= 1'b0;
          end
        end
        ST_CONV: begin
          if (sts_i.digit_done && sts_i.quot_zero) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q     <= ST_SHOW;
          out_valid_q <= 1'b1;
        end
        ST_SHOW: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (sts_i.cnt_one) begin
              state_q    <= ST_IDLE;
              in_ready_q <= 1'b1;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/unsigned_radix_to_ascii.sv -----
`timescale 1ns / 1ps
// One value is converted at a time: a new value is accepted only after the
// final character of the last one has been transferred.
// A 64-bit value gives at most 20 decimal digits (binary: 64 digits).
// Reset: asynchronous, active low; returns to idle with input ready high.
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii
// Writes an unsigned number out as ASCII digits in decimal, hex, octal or
// binary, most significant character first, flagging the final one.
// ----------------------------------------------------------------------------
//
// Structure
//   ura_controller  - sequencer: idle, convert, read, show.
//   ura_datapath    - digit extraction, a digit store with one write and one
//                     registered read port, and the character mapping.
//
// Conversion
//   Digits come out least significant first and are written to the store.
//   Power-of-two radices peel one digit per cycle by masking and shifting.
//   Decimal runs a long division by ten over the value, one byte per cycle,
//   using a reciprocal multiply on a 12-bit partial dividend; each full pass
//   yields one remainder digit and leaves the quotient in place.
//   Conversion stops once the quotient is zero, so a zero value still gives
//   the single character '0'.
//
// Emission
//   Read the store from the top entry down; each character is held on the
//   output until its transfer, and last_digit_o marks the final one.
//   Bits of value_i above VALUE_WIDTH are dropped.
//
module unsigned_radix_to_ascii #(
  parameter int unsigned VALUE_WIDTH = ura_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ura_pkg::VALUE_BITS-1:0] value_i,
  input  logic [1:0]                     radix_code_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ura_pkg::CHAR_W-1:0]     digit_char_o,
  output logic                           last_digit_o
);

  ura_pkg::ura_cmd_t cmd;
  ura_pkg::ura_sts_t sts;

  // Sequencer: owns the handshake flags
  ura_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: value register, divider step, digit store
  ura_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .radix_code_i (radix_code_i),
    .digit_char_o (digit_char_o)
  );

  // The character shown is the last one left in the store
  assign last_digit_o = sts.cnt_one;

endmodule

// ----- design/ura_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ura_checker
// Port-level checks of the radix-to-ASCII converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "unsigned_radix_to_ascii_macros.svh"

module ura_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ura_pkg::CHAR_W-1:0]     digit_char_o,
  input logic                           last_digit_o
);

  logic char_ok;

  assign char_ok = ((digit_char_o >= 7'd48) && (digit_char_o <= 7'd57)) ||
                   ((digit_char_o >= 7'd97) && (digit_char_o <= 7'd102));

  `URA_ASSERT_IMP(a_no_overlap, out_valid_o, !in_ready_o, "input ready while output pending")
  `URA_ASSERT_NXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o, "not busy after input transfer")
  `URA_ASSERT_NXT(a_last_frees, out_valid_o && out_ready_i && last_digit_o, in_ready_o, "input not ready after final character")
  `URA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(digit_char_o) && $stable(last_digit_o), "stalled output changed")
  `URA_ASSERT_IMP(a_char_range, out_valid_o, char_ok, "character outside digit set")

endmodule

bind unsigned_radix_to_ascii ura_checker u_ura_checker (.*);
